### rtl/bmp_pkg.sv
// shared constants and types for the block mean pixelation block
package bmp_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_BLOCK    = 64;
	localparam int HEIGHT_LIMIT = 1024;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
	localparam int BLK_W  = $clog2(MAX_BLOCK);
	localparam int PIX_W  = 8;
	localparam int SUM_W  = PIX_W + 2 * BLK_W;
	localparam int CNT_W  = 2 * BLK_W + 1;
	localparam int DIVC_W = $clog2(SUM_W);

	localparam int BS_W  = 7;
	localparam int DIM_W = 11;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

### rtl/block_mean_pixelation.sv
// block mean pixelation: running block sums, shared bit-serial divider, apb registers
// Each pixel transfer has three steps: one to accept it, one for the registered read of
// the block column sum memory and one to add and write back. When a pixel closes a block,
// a restoring divider that resolves one quotient bit per cycle then forms the mean, and
// the ST_OUT state moves it into the output register once that register is free or being
// taken. pixel_ready is low while an item is in work.
// The sum memory needs no clearing: the first pixel of each block overwrites its entry.
module block_mean_pixelation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bmp_pkg::ADDR_W-1:0]  paddr,
	input  logic [bmp_pkg::DATA_W-1:0]  pwdata,
	output logic [bmp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  logic [7:0]                  pixel_value,
	input  logic                        frame_start,
	output logic                        block_valid,
	input  logic                        block_ready,
	output logic [9:0]                  block_row,
	output logic [9:0]                  block_col,
	output logic [7:0]                  block_mean,
	output logic                        frame_done
);

	localparam int COL_W  = bmp_pkg::COL_W;
	localparam int ROW_W  = bmp_pkg::ROW_W;
	localparam int BLK_W  = bmp_pkg::BLK_W;
	localparam int SUM_W  = bmp_pkg::SUM_W;
	localparam int CNT_W  = bmp_pkg::CNT_W;
	localparam int DIVC_W = bmp_pkg::DIVC_W;
	localparam int BS_W   = bmp_pkg::BS_W;
	localparam int DIM_W  = bmp_pkg::DIM_W;

	// configuration registers
	logic [BS_W-1:0]  block_size_q;
	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic             cfg_wr;
	logic [1:0]       cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= BS_W'(8);
			frame_width_q  <= DIM_W'(640);
			frame_height_q <= DIM_W'(480);
		end else if (cfg_wr) begin
			case (cfg_idx)
				bmp_pkg::REG_BLOCK_SIZE:   block_size_q   <= pwdata[BS_W-1:0];
				bmp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
				bmp_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			bmp_pkg::REG_BLOCK_SIZE:   prdata = {{(32-BS_W){1'b0}}, block_size_q};
			bmp_pkg::REG_FRAME_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, frame_width_q};
			bmp_pkg::REG_FRAME_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, frame_height_q};
			default:                   prdata = '0;
		endcase
	end

	// effective limits
	logic [BS_W-1:0]  bs;
	logic [DIM_W-1:0] fw;
	logic [DIM_W-1:0] fh;

	always_comb begin
		if (block_size_q == '0)
			bs = BS_W'(1);
		else if (block_size_q > BS_W'(bmp_pkg::MAX_BLOCK))
			bs = BS_W'(bmp_pkg::MAX_BLOCK);
		else
			bs = block_size_q;
		if (frame_width_q == '0)
			fw = DIM_W'(1);
		else if (frame_width_q > DIM_W'(bmp_pkg::MAX_WIDTH))
			fw = DIM_W'(bmp_pkg::MAX_WIDTH);
		else
			fw = frame_width_q;
		if (frame_height_q == '0)
			fh = DIM_W'(1);
		else if (frame_height_q > DIM_W'(bmp_pkg::HEIGHT_LIMIT))
			fh = DIM_W'(bmp_pkg::HEIGHT_LIMIT);
		else
			fh = frame_height_q;
	end

	// sequencer
	bmp_pkg::state_t state_q, state_d;
	logic [DIVC_W-1:0] div_cnt_q;
	logic              load_out;

	// position state
	logic [COL_W-1:0] pcol_q;
	logic [ROW_W-1:0] prow_q;
	logic [BLK_W-1:0] cib_q;
	logic [BLK_W-1:0] rib_q;
	logic [COL_W-1:0] cur_bcol_q;
	logic [ROW_W-1:0] cur_brow_q;
	logic [7:0]       pix_q;

	// sum memory
	logic [SUM_W-1:0] sums_mem [bmp_pkg::MAX_WIDTH];
	logic [SUM_W-1:0] rd_data_q;
	logic             mem_we;
	logic [SUM_W-1:0] new_sum;

	// divider and pending result
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W:0]   rem_sh;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic [9:0]       pend_row_q;
	logic [9:0]       pend_col_q;
	logic             pend_done_q;
	logic [7:0]       mean_sat;

	// output register
	logic             out_valid_q;
	logic [9:0]       out_row_q;
	logic [9:0]       out_col_q;
	logic [7:0]       out_mean_q;
	logic             out_done_q;

	// update stage decode
	logic end_col, end_row, end_bcol, end_brow, blk_last, bs_col, bs_row;
	logic [CNT_W-1:0] count_d;

	assign end_col  = ({1'b0, pcol_q} + DIM_W'(1)) >= fw;
	assign end_row  = ({1'b0, prow_q} + DIM_W'(1)) >= fh;
	assign bs_col   = ({1'b0, cib_q} + BS_W'(1)) >= bs;
	assign bs_row   = ({1'b0, rib_q} + BS_W'(1)) >= bs;
	assign end_bcol = end_col || bs_col;
	assign end_brow = end_row || bs_row;
	assign blk_last = end_bcol && end_brow;
	assign count_d  = ({{(CNT_W-BLK_W){1'b0}}, cib_q} + CNT_W'(1))
	                * ({{(CNT_W-BLK_W){1'b0}}, rib_q} + CNT_W'(1));

	assign new_sum = (cib_q == '0 && rib_q == '0) ? SUM_W'(pix_q)
	                                               : rd_data_q + SUM_W'(pix_q);
	assign mem_we  = (state_q == bmp_pkg::ST_UPDATE);

	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign diff   = rem_sh - {1'b0, count_q};
	assign ge     = !diff[CNT_W];

	assign mean_sat = (quo_q > SUM_W'(255)) ? 8'd255 : quo_q[7:0];

	always_comb begin
		state_d     = state_q;
		pixel_ready = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			bmp_pkg::ST_IDLE: begin
				pixel_ready = 1'b1;
				if (pixel_valid)
					state_d = bmp_pkg::ST_READ;
			end
			bmp_pkg::ST_READ:   state_d = bmp_pkg::ST_UPDATE;
			bmp_pkg::ST_UPDATE: state_d = blk_last ? bmp_pkg::ST_DIV : bmp_pkg::ST_IDLE;
			bmp_pkg::ST_DIV: begin
				if (div_cnt_q == '0)
					state_d = bmp_pkg::ST_OUT;
			end
			bmp_pkg::ST_OUT: begin
				if (!out_valid_q || block_ready) begin
					load_out = 1'b1;
					state_d  = bmp_pkg::ST_IDLE;
				end
			end
			default: state_d = bmp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bmp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q     <= '0;
			prow_q     <= '0;
			cib_q      <= '0;
			rib_q      <= '0;
			cur_bcol_q <= '0;
			cur_brow_q <= '0;
		end else if (state_q == bmp_pkg::ST_IDLE && pixel_valid && frame_start) begin
			pcol_q     <= '0;
			prow_q     <= '0;
			cib_q      <= '0;
			rib_q      <= '0;
			cur_bcol_q <= '0;
			cur_brow_q <= '0;
		end else if (state_q == bmp_pkg::ST_UPDATE) begin
			if (end_col) begin
				pcol_q     <= '0;
				cib_q      <= '0;
				cur_bcol_q <= '0;
				if (end_row) begin
					prow_q     <= '0;
					rib_q      <= '0;
					cur_brow_q <= '0;
				end else begin
					prow_q <= prow_q + ROW_W'(1);
					if (bs_row) begin
						rib_q      <= '0;
						cur_brow_q <= cur_brow_q + ROW_W'(1);
					end else begin
						rib_q <= rib_q + BLK_W'(1);
					end
				end
			end else begin
				pcol_q <= pcol_q + COL_W'(1);
				if (bs_col) begin
					cib_q      <= '0;
					cur_bcol_q <= cur_bcol_q + COL_W'(1);
				end else begin
					cib_q <= cib_q + BLK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bmp_pkg::ST_IDLE && pixel_valid)
			pix_q <= pixel_value;
	end

	// block column sum memory
	always_ff @(posedge clk) begin
		if (mem_we)
			sums_mem[cur_bcol_q] <= new_sum;
		rd_data_q <= sums_mem[cur_bcol_q];
	end

	// shared restoring divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (state_q == bmp_pkg::ST_UPDATE)
			div_cnt_q <= DIVC_W'(SUM_W - 1);
		else if (state_q == bmp_pkg::ST_DIV && div_cnt_q != '0)
			div_cnt_q <= div_cnt_q - DIVC_W'(1);
	end

	always_ff @(posedge clk) begin
		if (state_q == bmp_pkg::ST_UPDATE) begin
			quo_q       <= new_sum;
			rem_q       <= '0;
			count_q     <= count_d;
			pend_row_q  <= cur_brow_q;
			pend_col_q  <= cur_bcol_q;
			pend_done_q <= end_col && end_row;
		end else if (state_q == bmp_pkg::ST_DIV) begin
			rem_q <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (block_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row_q  <= pend_row_q;
			out_col_q  <= pend_col_q;
			out_mean_q <= mean_sat;
			out_done_q <= pend_done_q;
		end
	end

	assign block_valid = out_valid_q;
	assign block_row   = out_row_q;
	assign block_col   = out_col_q;
	assign block_mean  = out_mean_q;
	assign frame_done  = out_done_q;

endmodule

### rtl/bmp_checker.sv
// port-level checks for block_mean_pixelation and their bind
module bmp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pready,
	input logic                        pixel_valid,
	input logic                        pixel_ready,
	input logic                        block_valid,
	input logic                        block_ready,
	input logic [9:0]                  block_row,
	input logic [9:0]                  block_col,
	input logic [7:0]                  block_mean,
	input logic                        frame_done
);

	// a pixel transfer keeps the input closed for read and update
	a_busy_after_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> !pixel_ready ##1 !pixel_ready)
		else $error("pixel_ready high during pixel work");

	// a new result only appears out of a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(block_valid) |-> $past(!pixel_ready))
		else $error("result appeared without work in progress");

	// a pending result holds until its transfer
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && !block_ready |=> block_valid && $stable(block_row)
			&& $stable(block_col) && $stable(block_mean) && $stable(frame_done))
		else $error("result changed before transfer");

	// register port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind block_mean_pixelation bmp_checker u_bmp_checker (.*);

### tb/tb_block_mean_pixelation.sv
// self-checking testbench for the block mean pixelation block: random pixel streams, apb setup
module tb_block_mean_pixelation;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] value;
		logic       start;
	} pixel_item_t;

	typedef struct {
		logic [9:0] row;
		logic [9:0] col;
		logic [7:0] mean;
		logic       done;
	} block_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [bmp_pkg::ADDR_W-1:0] paddr = '0;
	logic [bmp_pkg::DATA_W-1:0] pwdata = '0;
	logic [bmp_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	logic                       pixel_valid = 1'b0;
	logic                       pixel_ready;
	logic [7:0]                 pixel_value = '0;
	logic                       frame_start = 1'b0;
	logic                       block_valid;
	logic                       block_ready = 1'b0;
	logic [9:0]                 block_row;
	logic [9:0]                 block_col;
	logic [7:0]                 block_mean;
	logic                       frame_done;

	block_mean_pixelation dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_value (pixel_value),
		.frame_start (frame_start),
		.block_valid (block_valid),
		.block_ready (block_ready),
		.block_row   (block_row),
		.block_col   (block_col),
		.block_mean  (block_mean),
		.frame_done  (frame_done)
	);

	always #6 clk = ~clk;

	// register copies and block position state of the predictor
	logic [6:0]    cfg_block_size = 7'd8;
	logic [10:0]   cfg_frame_width = 11'd640;
	logic [10:0]   cfg_frame_height = 11'd480;
	int unsigned   pix_x = 0;
	int unsigned   pix_y = 0;
	int unsigned   x_in_blk = 0;
	int unsigned   y_in_blk = 0;
	int unsigned   blk_x = 0;
	int unsigned   blk_y = 0;
	int unsigned   column_sums [bmp_pkg::MAX_WIDTH];

	pixel_item_t   pixel_fifo [$];
	block_result_t pending_blocks [$];
	pixel_item_t   next_pixel;
	block_result_t want;

	int pixels_queued = 0;
	int pixels_accepted = 0;
	int blocks_checked = 0;
	int mismatches = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int sink_draw = 0;
	int src_max = 0;
	int sink_max = 0;
	logic hold_sink = 1'b0;

	function automatic int unsigned effective(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic accumulate_pixel(input logic [7:0] pix, input logic start);
		int unsigned bs, fw, fh, slot, count, mean;
		bit end_col, end_row, end_bcol, end_brow;
		block_result_t res;
		bs = effective(32'(cfg_block_size), bmp_pkg::MAX_BLOCK);
		fw = effective(32'(cfg_frame_width), bmp_pkg::MAX_WIDTH);
		fh = effective(32'(cfg_frame_height), bmp_pkg::HEIGHT_LIMIT);
		if (start) begin
			pix_x = 0;
			pix_y = 0;
			x_in_blk = 0;
			y_in_blk = 0;
			blk_x = 0;
			blk_y = 0;
		end
		slot = blk_x % bmp_pkg::MAX_WIDTH;
		if (x_in_blk == 0 && y_in_blk == 0)
			column_sums[slot] = 32'(pix);
		else
			column_sums[slot] += 32'(pix);
		end_col = pix_x + 1 >= fw;
		end_row = pix_y + 1 >= fh;
		end_bcol = end_col || x_in_blk + 1 >= bs;
		end_brow = end_row || y_in_blk + 1 >= bs;
		if (end_bcol && end_brow) begin
			count = (x_in_blk + 1) * (y_in_blk + 1);
			mean = column_sums[slot] / count;
			// only sums built across a settings change can exceed a pixel
			if (mean > 255)
				mean = 255;
			res.row = 10'(blk_y);
			res.col = 10'(blk_x);
			res.mean = 8'(mean);
			res.done = end_col && end_row;
			pending_blocks.push_back(res);
		end
		if (end_col) begin
			pix_x = 0;
			x_in_blk = 0;
			blk_x = 0;
			if (end_row) begin
				pix_y = 0;
				y_in_blk = 0;
				blk_y = 0;
			end else begin
				pix_y++;
				if (y_in_blk + 1 >= bs) begin
					y_in_blk = 0;
					blk_y++;
				end else begin
					y_in_blk++;
				end
			end
		end else begin
			pix_x++;
			if (x_in_blk + 1 >= bs) begin
				x_in_blk = 0;
				blk_x++;
			end else begin
				x_in_blk++;
			end
		end
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel_value <= '0;
			frame_start <= 1'b0;
			src_gap <= 0;
		end else begin
			if (pixel_valid && pixel_ready) begin
				accumulate_pixel(pixel_value, frame_start);
				pixels_accepted++;
			end
			if (!pixel_valid || pixel_ready) begin
				if (src_gap > 0) begin
					pixel_valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pixel_fifo.size() != 0) begin
					next_pixel = pixel_fifo.pop_front();
					pixel_valid <= 1'b1;
					pixel_value <= next_pixel.value;
					frame_start <= next_pixel.start;
					src_gap <= $urandom_range(0, src_max);
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// block result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_ready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (block_valid && block_ready) begin
				blocks_checked++;
				if (pending_blocks.size() == 0) begin
					report_mismatch($sformatf("block (%0d,%0d) mean %0d with none expected",
						block_row, block_col, block_mean));
				end else begin
					want = pending_blocks.pop_front();
					if (block_row !== want.row)
						report_mismatch($sformatf("block_row got %0d want %0d",
							block_row, want.row));
					if (block_col !== want.col)
						report_mismatch($sformatf("block_col got %0d want %0d",
							block_col, want.col));
					if (block_mean !== want.mean)
						report_mismatch($sformatf("block_mean of (%0d,%0d) got %0d want %0d",
							want.row, want.col, block_mean, want.mean));
					if (frame_done !== want.done)
						report_mismatch($sformatf("frame_done of (%0d,%0d) got %0b want %0b",
							want.row, want.col, frame_done, want.done));
				end
				sink_draw = $urandom_range(0, sink_max);
				sink_gap <= sink_draw;
				block_ready <= (sink_draw == 0) && !hold_sink;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				block_ready <= (sink_gap == 1) && !hold_sink;
			end else begin
				block_ready <= !hold_sink;
			end
		end
	end

	// long receiver stall so the block backs up into its pixel input
	initial begin
		wait (blocks_checked >= 40);
		@(posedge clk);
		hold_sink <= 1'b1;
		repeat (400) @(posedge clk);
		hold_sink <= 1'b0;
	end

	initial begin
		#24_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [bmp_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			bmp_pkg::REG_BLOCK_SIZE:   cfg_block_size = val[6:0];
			bmp_pkg::REG_FRAME_WIDTH:  cfg_frame_width = val[10:0];
			bmp_pkg::REG_FRAME_HEIGHT: cfg_frame_height = val[10:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained;
		do @(negedge clk);
		while (pixels_accepted != pixels_queued || pending_blocks.size() != 0);
		// a pixel that closes no block may still be in work
		repeat (30) @(negedge clk);
	endtask

	task automatic apply_settings(input int unsigned bs, input int unsigned w,
			input int unsigned h);
		wait_drained;
		write_reg(bmp_pkg::REG_BLOCK_SIZE, bs);
		write_reg(bmp_pkg::REG_FRAME_WIDTH, w);
		write_reg(bmp_pkg::REG_FRAME_HEIGHT, h);
	endtask

	task automatic push_pixel(input logic [7:0] v, input logic s);
		pixel_fifo.push_back('{value: v, start: s});
		pixels_queued++;
	endtask

	task automatic queue_frame(input bit lead_start, input bit allow_cut);
		int unsigned n, i;
		int fill;
		logic [7:0] v;
		n = effective(32'(cfg_frame_width), bmp_pkg::MAX_WIDTH)
			* effective(32'(cfg_frame_height), bmp_pkg::HEIGHT_LIMIT);
		if (allow_cut && $urandom_range(0, 5) == 0)
			n = $urandom_range(1, n);
		fill = $urandom_range(0, 3);
		for (i = 0; i < n; i++) begin
			case (fill)
				1: v = 8'hFF;
				2: v = 8'h00;
				3: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default: v = 8'($urandom_range(0, 255));
			endcase
			push_pixel(v, lead_start && i == 0);
		end
	endtask

	initial begin
		int i, frames;
		int unsigned bs, w, h;
		wait (arst_n);
		@(negedge clk);

		// every register at zero: each pixel is a frame of one block
		apply_settings(0, 0, 0);
		push_pixel(8'h00, 1'b1);
		push_pixel(8'hFF, 1'b0);
		push_pixel(8'h55, 1'b0);
		push_pixel(8'hAA, 1'b1);

		// 3x3 frame in 2x2 blocks: partial blocks on the right and bottom edges
		apply_settings(2, 3, 3);
		for (i = 0; i < 8; i++)
			push_pixel(8'(10 + i), i == 0);
		push_pixel(8'hFF, 1'b0);
		// frame cut short by a new frame_start
		for (i = 0; i < 4; i++)
			push_pixel(8'd200, i == 0);
		for (i = 0; i < 9; i++)
			push_pixel(8'hFF, i == 0);

		// settings change inside a frame, mean saturates
		src_max = 3;
		sink_max = 3;
		apply_settings(8, 16, 16);
		for (i = 0; i < 53; i++)
			push_pixel(8'hFF, i == 0);
		wait_drained;
		write_reg(bmp_pkg::REG_BLOCK_SIZE, 2);
		write_reg(bmp_pkg::REG_FRAME_WIDTH, 4);
		push_pixel(8'hFF, 1'b0);
		for (i = 0; i < 48; i++)
			push_pixel(8'($urandom_range(0, 255)), 1'b0);

		// widest row, one pixel per block
		apply_settings(0, 2047, 1);
		queue_frame(1'b1, 1'b0);

		// tallest column cut short, one pixel per block
		apply_settings(1, 1, 2047);
		for (i = 0; i < 24; i++)
			push_pixel(8'($urandom_range(0, 255)), i == 0);

		while (pixels_queued < 1350) begin
			case ($urandom_range(0, 7))
				0: bs = 0;
				1: bs = bmp_pkg::MAX_BLOCK;
				2: bs = $urandom_range(bmp_pkg::MAX_BLOCK + 1, 127);
				default: bs = $urandom_range(1, 6);
			endcase
			w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
			apply_settings(bs, w, h);
			case ($urandom_range(0, 2))
				0: src_max = 0;
				1: src_max = 3;
				default: src_max = 16;
			endcase
			case ($urandom_range(0, 2))
				0: sink_max = 0;
				1: sink_max = 3;
				default: sink_max = 16;
			endcase
			frames = $urandom_range(1, 3);
			for (i = 0; i < frames; i++)
				queue_frame(i == 0 || $urandom_range(0, 7) != 0, 1'b1);
		end

		wait_drained;
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
